// ===== rtl/core/agkf_pkg.sv =====
// ----------------------------------------------------------------------------
// agkf_pkg - shared types and constants of the angle/gyro Kalman fusion unit
// Register indexes, reset values, the control word of the multiply unit and
// the signed 32-bit saturation helper.
// ----------------------------------------------------------------------------
package agkf_pkg;

   localparam int unsigned WideW = 70;

   typedef enum logic [1:0] {
      CSR_Q_ANGLE   = 2'd0,
      CSR_Q_GYRO    = 2'd1,
      CSR_R_ANGLE   = 2'd2,
      CSR_STEP_TIME = 2'd3
   } csr_index_type;

   localparam logic [31:0] QAngleReset   = 32'd1073742;
   localparam logic [31:0] QGyroReset    = 32'd3221225;
   localparam logic [31:0] RAngleReset   = 32'd536870912;
   localparam logic [23:0] StepTimeReset = 24'd83886;
   localparam logic signed [31:0] OneQ30 = 32'sd1073741824;

   // Control of the shared multiply-accumulate unit.
   typedef struct packed {
      logic sub;      // subtract the rounded product instead of adding it
      logic shift30;  // round off 30 fraction bits instead of 24
   } mac_ctrl_type;

   function automatic logic signed [31:0] sat32(input logic signed [WideW-1:0] v);
      logic signed [WideW-1:0] hi;
      logic signed [WideW-1:0] lo;
      hi = WideW'(64'sd2147483647);
      lo = -WideW'(64'sd2147483648);
      if (v > hi) begin
         return 32'sh7fffffff;
      end else if (v < lo) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

endpackage

// ===== rtl/core/agkf_req_if.sv =====
// ----------------------------------------------------------------------------
// agkf_req_if - input channel of the fusion unit
// One beat carries one accelerometer angle and one gyro rate sample.
// ----------------------------------------------------------------------------
interface agkf_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] accel_angle;
   logic signed [31:0] gyro_rate;

   modport source (output valid, output accel_angle, output gyro_rate, input ready);
   modport sink (input valid, input accel_angle, input gyro_rate, output ready);
endinterface

// ===== rtl/core/agkf_rsp_if.sv =====
// ----------------------------------------------------------------------------
// agkf_rsp_if - result channel of the fusion unit
// One beat carries the angle, the bias-corrected rate and the bias.
// ----------------------------------------------------------------------------
interface agkf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] angle_est;
   logic signed [31:0] rate_est;
   logic signed [31:0] bias_est;

   modport source (output valid, output angle_est, output rate_est, output bias_est,
                   input ready);
   modport sink (input valid, input angle_est, input rate_est, input bias_est,
                 output ready);
endinterface

// ===== rtl/core/angle_gyro_kalman_fusion_unit.sv =====
// ----------------------------------------------------------------------------
// angle_gyro_kalman_fusion_unit - two-state angle and gyro bias Kalman filter
// Fuses accelerometer angle and gyro rate beats into angle, rate and bias.
// ----------------------------------------------------------------------------
// One beat is worked on at a time; the input is not ready while a beat is in
// flight. From acceptance to its result a beat takes eleven passes through
// the one shared multiplier, the innovation step, two runs of the gain
// divider and the load of the output register. The input is ready again as
// the result appears, so a new beat is accepted only once the last one is
// through. When the innovation denominator is not positive the divider is
// skipped. A new beat may be accepted while the previous result still
// waits in the output register; its own result then waits until that
// register is free.
module angle_gyro_kalman_fusion_unit
   import agkf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wr_en,
   input  csr_index_type csr_index,
   input  logic [31:0]   csr_wr_data,
   agkf_req_if.sink      req_bus,
   agkf_rsp_if.source    rsp_bus
);

   typedef enum logic [2:0] {
      S_IDLE, S_MUL, S_ACC, S_MEAS, S_DIV0, S_DIV1, S_OUT
   } state_type;

   typedef enum logic [3:0] {
      OP_ANG_T, OP_P00_T, OP_P01_T, OP_P10_T, OP_P11_T,
      OP_P10_M, OP_P11_M, OP_P00_M, OP_P01_M, OP_ANG_M, OP_BIAS_M
   } op_type;

   state_type state_ff;
   op_type    op_ff;

   logic [31:0] q_angle_ff, q_gyro_ff, r_angle_ff;
   logic [23:0] step_time_ff;
   logic signed [31:0] angle_ff, bias_ff, cov_aa_ff, cov_ab_ff, cov_ba_ff, cov_bb_ff;
   logic signed [31:0] accel_ff, gyro_ff, e_ff, k0_ff, k1_ff;
   logic signed [33:0] den_ff;
   logic        rsp_valid_ff;
   logic signed [31:0] rsp_angle_ff, rsp_rate_ff, rsp_bias_ff;

   logic signed [35:0] op_a;
   logic signed [32:0] op_b;
   logic signed [32:0] dt_b;
   mac_ctrl_type       ctrl;
   logic signed [31:0] acc;
   logic signed [31:0] mac_result;
   logic signed [33:0] den_in;
   logic signed [31:0] e_in;
   logic               div_start;
   logic signed [31:0] div_num;
   logic [32:0]        div_den;
   logic               div_done;
   logic signed [31:0] div_quot;
   logic               out_fire;

   assign dt_b = 33'(signed'({9'd0, step_time_ff}));

   always_comb begin
      op_a = '0;
      op_b = dt_b;
      acc  = angle_ff;
      ctrl = '{sub: 1'b0, shift30: 1'b0};
      case (op_ff)
         OP_ANG_T: begin
            op_a = 36'(gyro_ff) - 36'(bias_ff);
            acc  = angle_ff;
         end
         OP_P00_T: begin
            op_a = 36'(signed'({4'd0, q_angle_ff})) - 36'(cov_ab_ff) - 36'(cov_ba_ff);
            acc  = cov_aa_ff;
         end
         OP_P01_T: begin
            op_a = -36'(cov_bb_ff);
            acc  = cov_ab_ff;
         end
         OP_P10_T: begin
            op_a = -36'(cov_bb_ff);
            acc  = cov_ba_ff;
         end
         OP_P11_T: begin
            op_a = 36'(signed'({4'd0, q_gyro_ff}));
            acc  = cov_bb_ff;
         end
         OP_P10_M: begin
            op_a = 36'(k1_ff);
            op_b = 33'(cov_aa_ff);
            acc  = cov_ba_ff;
            ctrl = '{sub: 1'b1, shift30: 1'b1};
         end
         OP_P11_M: begin
            op_a = 36'(k1_ff);
            op_b = 33'(cov_ab_ff);
            acc  = cov_bb_ff;
            ctrl = '{sub: 1'b1, shift30: 1'b1};
         end
         OP_P00_M: begin
            op_a = 36'(k0_ff);
            op_b = 33'(cov_aa_ff);
            acc  = cov_aa_ff;
            ctrl = '{sub: 1'b1, shift30: 1'b1};
         end
         OP_P01_M: begin
            op_a = 36'(k0_ff);
            op_b = 33'(cov_ab_ff);
            acc  = cov_ab_ff;
            ctrl = '{sub: 1'b1, shift30: 1'b1};
         end
         OP_ANG_M: begin
            op_a = 36'(k0_ff);
            op_b = 33'(e_ff);
            acc  = angle_ff;
            ctrl = '{sub: 1'b0, shift30: 1'b1};
         end
         OP_BIAS_M: begin
            op_a = 36'(k1_ff);
            op_b = 33'(e_ff);
            acc  = bias_ff;
            ctrl = '{sub: 1'b0, shift30: 1'b1};
         end
         default: begin
            op_a = '0;
         end
      endcase
   end

   agkf_mac u_mac (
      .clock  (clock),
      .load   (state_ff == S_MUL),
      .op_a   (op_a),
      .op_b   (op_b),
      .ctrl   (ctrl),
      .acc    (acc),
      .result (mac_result)
   );

   assign den_in = 34'(signed'({2'b0, r_angle_ff})) + 34'(cov_aa_ff);
   assign e_in   = sat32(WideW'(accel_ff) - WideW'(angle_ff));

   // The first gain starts from the measurement step, the second as the first ends.
   assign div_start = ((state_ff == S_MEAS) && (den_in > 34'sd0)) ||
                      ((state_ff == S_DIV0) && div_done);
   assign div_num   = (state_ff == S_MEAS) ? cov_aa_ff : cov_ba_ff;
   assign div_den   = (state_ff == S_MEAS) ? den_in[32:0] : den_ff[32:0];

   agkf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign out_fire = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= OP_ANG_T;
         rsp_valid_ff <= 1'b0;
         q_angle_ff   <= QAngleReset;
         q_gyro_ff    <= QGyroReset;
         r_angle_ff   <= RAngleReset;
         step_time_ff <= StepTimeReset;
         angle_ff     <= '0;
         bias_ff      <= '0;
         cov_aa_ff    <= OneQ30;
         cov_ab_ff    <= '0;
         cov_ba_ff    <= '0;
         cov_bb_ff    <= OneQ30;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_Q_ANGLE:   q_angle_ff   <= csr_wr_data;
               CSR_Q_GYRO:    q_gyro_ff    <= csr_wr_data;
               CSR_R_ANGLE:   r_angle_ff   <= csr_wr_data;
               CSR_STEP_TIME: step_time_ff <= csr_wr_data[23:0];
               default: ;
            endcase
         end

         if (out_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_bus.valid) begin
                  accel_ff <= req_bus.accel_angle;
                  gyro_ff  <= req_bus.gyro_rate;
                  op_ff    <= OP_ANG_T;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               state_ff <= S_ACC;
            end
            S_ACC: begin
               case (op_ff)
                  OP_ANG_T, OP_ANG_M:   angle_ff  <= mac_result;
                  OP_BIAS_M:            bias_ff   <= mac_result;
                  OP_P00_T, OP_P00_M:   cov_aa_ff <= mac_result;
                  OP_P01_T, OP_P01_M:   cov_ab_ff <= mac_result;
                  OP_P10_T, OP_P10_M:   cov_ba_ff <= mac_result;
                  OP_P11_T, OP_P11_M:   cov_bb_ff <= mac_result;
                  default: ;
               endcase
               if (op_ff == OP_P11_T) begin
                  state_ff <= S_MEAS;
               end else if (op_ff == OP_BIAS_M) begin
                  state_ff <= S_OUT;
               end else begin
                  op_ff    <= op_type'(op_ff + 4'd1);
                  state_ff <= S_MUL;
               end
            end
            S_MEAS: begin
               e_ff   <= e_in;
               den_ff <= den_in;
               if (den_in > 34'sd0) begin
                  state_ff <= S_DIV0;
               end else begin
                  // Zero gains leave covariance and state as they are.
                  k0_ff    <= '0;
                  k1_ff    <= '0;
                  op_ff    <= OP_P10_M;
                  state_ff <= S_MUL;
               end
            end
            S_DIV0: begin
               if (div_done) begin
                  k0_ff    <= div_quot;
                  state_ff <= S_DIV1;
               end
            end
            S_DIV1: begin
               if (div_done) begin
                  k1_ff    <= div_quot;
                  op_ff    <= OP_P10_M;
                  state_ff <= S_MUL;
               end
            end
            S_OUT: begin
               if (out_fire) begin
                  rsp_angle_ff <= angle_ff;
                  rsp_bias_ff  <= bias_ff;
                  rsp_rate_ff  <= sat32(WideW'(gyro_ff) - WideW'(bias_ff));
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_bus.ready     = (state_ff == S_IDLE);
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.angle_est = rsp_angle_ff;
   assign rsp_bus.rate_est  = rsp_rate_ff;
   assign rsp_bus.bias_est  = rsp_bias_ff;

endmodule

// ===== rtl/core/agkf_mac.sv =====
// ----------------------------------------------------------------------------
// agkf_mac - shared multiply, round and accumulate unit
// Registers one signed product, then adds or subtracts it, rounded half up
// after 24 or 30 fraction bits, to an accumulator value and saturates.
// ----------------------------------------------------------------------------
module agkf_mac
   import agkf_pkg::*;
(
   input  logic               clock,
   input  logic               load,
   input  logic signed [35:0] op_a,
   input  logic signed [32:0] op_b,
   input  mac_ctrl_type       ctrl,
   input  logic signed [31:0] acc,
   output logic signed [31:0] result
);

   logic signed [68:0]       prod_ff;
   logic signed [68:0]       prod_in;
   logic signed [68:0]       rounded;
   logic signed [68:0]       shifted;
   logic signed [WideW-1:0]  total;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

   always_comb begin
      if (ctrl.shift30) begin
         rounded = prod_ff + (69'sd1 <<< 29);
         shifted = rounded >>> 30;
      end else begin
         rounded = prod_ff + (69'sd1 <<< 23);
         shifted = rounded >>> 24;
      end
      if (ctrl.sub) begin
         total = WideW'(acc) - WideW'(shifted);
      end else begin
         total = WideW'(acc) + WideW'(shifted);
      end
      result = sat32(total);
   end

endmodule

// ===== rtl/core/agkf_div.sv =====
// ----------------------------------------------------------------------------
// agkf_div - radix-2 gain divider
// Computes sat32(trunc(num * 2^30 / den)) for a positive denominator, one
// quotient bit per cycle, with an early overflow check.
// ----------------------------------------------------------------------------
module agkf_div
   import agkf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] num,
   input  logic        [32:0] den,
   output logic               done,
   output logic signed [31:0] quot
);

   logic        busy_ff;
   logic        done_ff;
   logic [4:0]  cnt_ff;
   logic        neg_ff;
   logic        ovf_ff;
   logic [32:0] den_ff;
   logic [32:0] rem_ff;
   logic [31:0] sh_ff;
   logic [31:0] q_ff;

   logic [31:0] mag;
   logic [33:0] trial;
   logic        fits;
   logic signed [WideW-1:0] signed_q;

   assign mag   = num[31] ? 32'(-num) : 32'(num);
   assign trial = {rem_ff, sh_ff[31]};
   assign fits  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= num[31];
         // The quotient needs more than 32 bits when |num| >= 4 * den.
         ovf_ff <= {5'd0, mag} >= {2'b0, den, 2'b00};
         den_ff <= den;
         rem_ff <= {3'd0, mag[31:2]};
         sh_ff  <= {mag[1:0], 30'd0};
         q_ff   <= '0;
      end else if (busy_ff) begin
         rem_ff <= fits ? 33'(trial - {1'b0, den_ff}) : trial[32:0];
         sh_ff  <= {sh_ff[30:0], 1'b0};
         q_ff   <= {q_ff[30:0], fits};
      end
   end

   always_comb begin
      if (neg_ff) begin
         signed_q = -WideW'({1'b0, q_ff});
      end else begin
         signed_q = WideW'({1'b0, q_ff});
      end
      if (ovf_ff) begin
         quot = neg_ff ? 32'sh80000000 : 32'sh7fffffff;
      end else begin
         quot = sat32(signed_q);
      end
   end

   assign done = done_ff;

endmodule

// ===== tb/agkf_fusion_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agkf_fusion_checker - result checker of the angle/gyro Kalman fusion unit
// Watches the configuration port and both channels, runs its own fixed-point
// model of the filter on every accepted input beat and compares each result
// beat field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module agkf_fusion_checker
   import agkf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wr_en,
   input  csr_index_type csr_index,
   input  logic [31:0]   csr_wr_data,
   input  logic          req_valid,
   input  logic          req_ready,
   input  logic [31:0]   req_accel,
   input  logic [31:0]   req_gyro,
   input  logic          rsp_valid,
   input  logic          rsp_ready,
   input  logic [31:0]   rsp_angle,
   input  logic [31:0]   rsp_rate,
   input  logic [31:0]   rsp_bias,
   output int            fail_count,
   output int            pending_count,
   output int            result_count
);

   typedef struct packed {
      logic [31:0] angle;
      logic [31:0] rate;
      logic [31:0] bias;
   } fusion_result_type;

   fusion_result_type expected_results[$];

   logic [31:0] mdl_q_angle, mdl_q_gyro, mdl_r_angle;
   logic [23:0] mdl_dt;
   longint mdl_angle, mdl_bias, mdl_p00, mdl_p01, mdl_p10, mdl_p11;

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Round half up: floor((v + 2^(s-1)) / 2^s), arithmetic shift gives floor.
   function automatic longint round_shift(input longint v, input int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic fusion_result_type filter_step(input logic [31:0] accel_in,
                                                     input logic [31:0] gyro_in);
      longint accel, gyro, dt, ang, bias, p00, p01, p10, p11;
      longint innov, den, k0, k1, t0, t1;
      fusion_result_type res;
      accel = longint'($signed(accel_in));
      gyro  = longint'($signed(gyro_in));
      dt    = longint'(mdl_dt);
      k0 = 0;
      k1 = 0;
      ang = clamp32(mdl_angle + round_shift((gyro - mdl_bias) * dt, 24));
      p00 = clamp32(mdl_p00 + round_shift((longint'(mdl_q_angle) - mdl_p01 - mdl_p10) * dt, 24));
      p01 = clamp32(mdl_p01 + round_shift(-mdl_p11 * dt, 24));
      p10 = clamp32(mdl_p10 + round_shift(-mdl_p11 * dt, 24));
      p11 = clamp32(mdl_p11 + round_shift(longint'(mdl_q_gyro) * dt, 24));
      innov = clamp32(accel - ang);
      den = longint'(mdl_r_angle) + p00;
      if (den > 0) begin
         k0 = clamp32((p00 * 64'sd1073741824) / den);
         k1 = clamp32((p10 * 64'sd1073741824) / den);
      end
      t0 = p00;
      t1 = p01;
      p00 = clamp32(p00 - round_shift(k0 * t0, 30));
      p01 = clamp32(p01 - round_shift(k0 * t1, 30));
      p10 = clamp32(p10 - round_shift(k1 * t0, 30));
      p11 = clamp32(p11 - round_shift(k1 * t1, 30));
      ang  = clamp32(ang + round_shift(k0 * innov, 30));
      bias = clamp32(mdl_bias + round_shift(k1 * innov, 30));
      mdl_angle = ang;
      mdl_bias  = bias;
      mdl_p00 = p00;
      mdl_p01 = p01;
      mdl_p10 = p10;
      mdl_p11 = p11;
      res.angle = ang[31:0];
      res.rate  = 32'(clamp32(gyro - bias));
      res.bias  = bias[31:0];
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t mismatch %s: got %h, expected %h", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      fusion_result_type want;
      if (reset) begin
         mdl_q_angle <= QAngleReset;
         mdl_q_gyro  <= QGyroReset;
         mdl_r_angle <= RAngleReset;
         mdl_dt      <= StepTimeReset;
         mdl_angle = 0;
         mdl_bias  = 0;
         mdl_p00 = 64'sd1073741824;
         mdl_p01 = 0;
         mdl_p10 = 0;
         mdl_p11 = 64'sd1073741824;
         expected_results.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_Q_ANGLE:   mdl_q_angle <= csr_wr_data;
               CSR_Q_GYRO:    mdl_q_gyro  <= csr_wr_data;
               CSR_R_ANGLE:   mdl_r_angle <= csr_wr_data;
               CSR_STEP_TIME: mdl_dt      <= csr_wr_data[23:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            result_count++;
            if (expected_results.size() == 0) begin
               $display("%0t result beat with no prediction waiting", $realtime);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_angle !== want.angle) report_mismatch("angle_est", rsp_angle, want.angle);
               if (rsp_rate !== want.rate) report_mismatch("rate_est", rsp_rate, want.rate);
               if (rsp_bias !== want.bias) report_mismatch("bias_est", rsp_bias, want.bias);
            end
         end
         if (req_valid && req_ready)
            expected_results.push_back(filter_step(req_accel, req_gyro));
      end
      pending_count = expected_results.size();
   end

   initial begin
      fail_count = 0;
      pending_count = 0;
      result_count = 0;
   end

endmodule

// ===== tb/tb_angle_gyro_kalman_fusion_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_angle_gyro_kalman_fusion_unit - testbench of the Kalman fusion unit
// Drives directed and random sample beats in bursts under several register
// settings, stalls the result side on its own pattern and leaves the checking
// to the checker module.
// ----------------------------------------------------------------------------
module tb_angle_gyro_kalman_fusion_unit;
   import agkf_pkg::*;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          csr_wr_en = 1'b0;
   csr_index_type csr_index = CSR_Q_ANGLE;
   logic [31:0]   csr_wr_data = '0;
   int            fail_count, pending_count, result_count;
   int            beats_sent = 0;
   bit            long_hold = 1'b0;
   bit            stimulus_done = 1'b0;

   agkf_req_if req_bus ();
   agkf_rsp_if rsp_bus ();

   angle_gyro_kalman_fusion_unit uut (
      .clock(clock), .reset(reset), .csr_wr_en(csr_wr_en), .csr_index(csr_index),
      .csr_wr_data(csr_wr_data), .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source)
   );

   agkf_fusion_checker checker_inst (
      .clock(clock), .reset(reset), .csr_wr_en(csr_wr_en), .csr_index(csr_index),
      .csr_wr_data(csr_wr_data),
      .req_valid(req_bus.valid), .req_ready(req_bus.ready),
      .req_accel(req_bus.accel_angle), .req_gyro(req_bus.gyro_rate),
      .rsp_valid(rsp_bus.valid), .rsp_ready(rsp_bus.ready),
      .rsp_angle(rsp_bus.angle_est), .rsp_rate(rsp_bus.rate_est),
      .rsp_bias(rsp_bus.bias_est),
      .fail_count(fail_count), .pending_count(pending_count), .result_count(result_count)
   );

   always #10 clock = ~clock;

   initial begin
      req_bus.valid = 1'b0;
      req_bus.accel_angle = '0;
      req_bus.gyro_rate = '0;
      rsp_bus.ready = 1'b0;
   end

   // Offers one beat and holds it until the block takes it.
   task automatic send_sample(input logic [31:0] accel, input logic [31:0] gyro);
      req_bus.valid       <= 1'b1;
      req_bus.accel_angle <= accel;
      req_bus.gyro_rate   <= gyro;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      beats_sent++;
   endtask

   task automatic idle_sender(input int cycles);
      req_bus.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Registers change only once every result is in and the block has settled.
   task automatic drain_and_settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [31:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
   endtask

   task automatic apply_setting(input logic [31:0] qa, input logic [31:0] qg,
                                input logic [31:0] ra, input logic [31:0] dt);
      write_register(CSR_Q_ANGLE, qa);
      write_register(CSR_Q_GYRO, qg);
      write_register(CSR_R_ANGLE, ra);
      write_register(CSR_STEP_TIME, dt);
      csr_wr_en <= 1'b0;
   endtask

   // Mostly small angles and rates near a slow trajectory, sometimes full range.
   function automatic logic [31:0] rand_signal(input int base);
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return ($urandom_range(0, 1) != 0) ? 32'h7fffffff : 32'h80000000;
         default: return base + $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      endcase
   endfunction

   task automatic random_phase(input int count);
      int burst;
      int base_angle;
      base_angle = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      while (count > 0) begin
         burst = $urandom_range(1, 40);
         while (burst > 0 && count > 0) begin
            base_angle += $signed($urandom_range(0, 2000)) - 1000;
            send_sample(rand_signal(base_angle), rand_signal(0));
            burst--;
            count--;
         end
         // Sometimes the next burst follows with no gap at all.
         if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 150));
      end
   endtask

   // Result side: random stall pattern, ready constantly high for stretches.
   initial begin
      int mode;
      int span;
      mode = 0;
      span = 0;
      @(posedge clock);
      while (1) begin
         if (span == 0) begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(20, 400);
         end
         span--;
         if (long_hold)
            rsp_bus.ready <= 1'b0;
         else if (mode == 0)
            rsp_bus.ready <= 1'b1;
         else if (mode == 1)
            rsp_bus.ready <= ($urandom_range(0, 3) != 0);
         else
            rsp_bus.ready <= ($urandom_range(0, 4) == 0);
         @(posedge clock);
      end
   end

   // Long hold-off of the result side, counted in cycles, while the sender keeps offering.
   initial begin
      wait (beats_sent >= 200);
      @(posedge clock);
      long_hold = 1'b1;
      repeat (1500) @(posedge clock);
      long_hold = 1'b0;
   end

   initial begin
      logic [31:0] extremes[6];
      extremes = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff, 32'h00010000, 32'hffff0000};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes of both fields under the reset setting.
      foreach (extremes[i]) send_sample(extremes[i], extremes[5 - i]);
      send_sample(32'h7fffffff, 32'h7fffffff);
      send_sample(32'h80000000, 32'h80000000);
      send_sample(32'h00005000, 32'hfffff000);
      drain_and_settle();

      // Register extremes: maximum noise and step, then all registers at zero.
      apply_setting(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'h00ffffff);
      foreach (extremes[i]) send_sample(extremes[i], extremes[i]);
      drain_and_settle();
      apply_setting(32'h0, 32'h0, 32'h0, 32'h0);
      repeat (4) send_sample(32'h00020000, 32'h00010000);
      drain_and_settle();
      apply_setting(QAngleReset, QGyroReset, RAngleReset, StepTimeReset);

      random_phase(500);
      // The sender waits here until every result is back.
      drain_and_settle();
      apply_setting($urandom(), $urandom(), $urandom(), $urandom_range(0, 24'hffffff));
      random_phase(300);
      drain_and_settle();
      apply_setting(32'd1073742, 32'd3221225, 32'h0000_0001, 24'd1);
      random_phase(300);
      drain_and_settle();
      apply_setting(32'h0010_0000, 32'h0001_0000, 32'h4000_0000, 24'h01_0000);
      random_phase(600);

      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      $display("Sent %0d sample beats under seven register settings; %0d results checked.",
               beats_sent, result_count);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #(60_000_000);
      $display("Timeout with %0d results still outstanding.", pending_count);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/agkf_pkg.sv
rtl/core/agkf_req_if.sv
rtl/core/agkf_rsp_if.sv
rtl/core/agkf_mac.sv
rtl/core/agkf_div.sv
rtl/core/angle_gyro_kalman_fusion_unit.sv
tb/agkf_fusion_checker.sv
tb/tb_angle_gyro_kalman_fusion_unit.sv
